// ===== rtl/mcg_pkg.sv =====
// metronome click generator package: fixed constants, state encoding, sine table
// no dependencies; used by metronome_click_generator_top
package mcg_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int PHASE_BITS       = 32;
    localparam int MAX_BAR_BEATS    = 32;
    localparam int BAR_BITS         = $clog2(MAX_BAR_BEATS);

    localparam int FULL_SCALE       = 32767;
    localparam int ACCENT_GAIN_Q15  = 29491;
    localparam int NORMAL_GAIN_Q15  = 18022;
    localparam int ACCENT_FREQ_HZ   = 1500;
    localparam int NORMAL_FREQ_HZ   = 1000;
    localparam int CLICK_DIVISOR    = 200;
    localparam int SECONDS_PER_MIN  = 60;

    // rate/200 as ((rate >> 3) * CLICK_RECIP) >> 20, exact for rates up to 192000
    localparam int CLICK_RECIP      = 41944;

    localparam int BPM_MIN  = 1;
    localparam int BPM_MAX  = 600;
    localparam int RATE_MIN = 8000;
    localparam int RATE_MAX = 192000;

    // shared divider sizes
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // register indexes on the config port
    localparam logic [1:0] REG_BPM  = 2'd0;
    localparam logic [1:0] REG_BPB  = 2'd1;
    localparam logic [1:0] REG_RATE = 2'd2;

    // derivation steps; all but DIV_CLICK_LEN run through the divider
    localparam logic [2:0] DIV_BEAT_PERIOD = 3'd0;
    localparam logic [2:0] DIV_CLICK_LEN   = 3'd1;
    localparam logic [2:0] DIV_ENV_SCALE   = 3'd2;
    localparam logic [2:0] DIV_NORMAL_STEP = 3'd3;
    localparam logic [2:0] DIV_ACCENT_STEP = 3'd4;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_DIV_LD  = 11'b000_0000_0010,
        S_DIV     = 11'b000_0000_0100,
        S_BEAT    = 11'b000_0000_1000,
        S_MOD     = 11'b000_0001_0000,
        S_MUL_T   = 11'b000_0010_0000,
        S_MUL_ENV = 11'b000_0100_0000,
        S_MUL_SG  = 11'b000_1000_0000,
        S_MUL_P   = 11'b001_0000_0000,
        S_SAMPLE  = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } state_t;

    typedef logic signed [15:0] sine_table_t [SINE_TABLE_DEPTH];

    // quarter-wave Q30 odd polynomial, evaluated at elaboration
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        longint u, q, r, x, x2, p, s, v;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            u = (longint'(i) <<< 32) / SINE_TABLE_DEPTH;
            q = (u >>> 30) & 3;
            r = u & 64'h3FFF_FFFF;
            if (q[0])
                r = 64'sd1073741824 - r;
            x  = r;
            x2 = (x * x) / 64'sd1073741824;
            p  = 64'sd172272;
            p  = -64'sd5026995 + (p * x2) / 64'sd1073741824;
            p  = 64'sd85569304 + (p * x2) / 64'sd1073741824;
            p  = -64'sd693598668 + (p * x2) / 64'sd1073741824;
            p  = 64'sd1686629713 + (p * x2) / 64'sd1073741824;
            s  = (p * x) / 64'sd1073741824;
            if (s < 0)
                s = 0;
            v = (s * FULL_SCALE + 64'sd536870912) / 64'sd1073741824;
            if (v > FULL_SCALE)
                v = FULL_SCALE;
            if (q >= 2)
                v = -v;
            tbl[i] = 16'(v);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ===== rtl/metronome_click_generator_top.sv =====
// metronome click generator: one audio sample per input frame, with beat markers
// depends on mcg_pkg (constants, state encoding, sine table)
//
// sequencing: one frame at a time; a frame while a click sounds passes idle, beat,
// four multiplier passes, sample and output, a silent frame idle, beat and output,
// each plus any output stall; a beat frame adds the bar-position wrap, and a frame
// after reset, restart or a register write adds four 48-step divisions and one multiply
// reset: asynchronous, active low; registers return to 120 bpm, 4 beats, 48 kHz.
module metronome_click_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    // input frames
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // result samples
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] sample, [16] beat_start,
                                   // [21:17] beat_index, [22] accent, [23] zero
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PB = mcg_pkg::PHASE_BITS;
    localparam int BB = mcg_pkg::BAR_BITS;
    localparam int NW = mcg_pkg::DIV_NUM_W;
    localparam int DW = mcg_pkg::DIV_DEN_W;
    localparam int CW = mcg_pkg::DIV_CNT_W;

    mcg_pkg::state_t state_reg, state_next;

    logic [9:0]  bpm_reg;
    logic [5:0]  bpb_reg;
    logic [17:0] rate_reg;
    logic        stale_reg;

    logic [23:0]   ftb_reg, ftb_next;
    logic [BB-1:0] bar_reg, bar_next;
    logic [9:0]    cfl_reg, cfl_next;
    logic [PB-1:0] phase_reg, phase_next;
    logic [PB-1:0] step_reg, step_next;
    logic [14:0]   gain_reg, gain_next;
    logic [23:0]   period_reg, period_next;
    logic [9:0]    clen_reg, clen_next;
    logic [16:0]   escale_reg, escale_next;
    logic [PB-1:0] nstep_reg, nstep_next;
    logic [PB-1:0] astep_reg, astep_next;
    logic          stale_clr;

    // divider
    logic [2:0]    dsel_reg, dsel_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   rem_shift;

    // bar wrap
    logic [BB:0]   mod_reg, mod_next;

    // multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [63:0] prod_reg, prod_next;
    logic [16:0]        env_reg, env_next;

    // result of the frame
    logic signed [15:0] smp_reg, smp_next;
    logic               beat_reg, beat_next;
    logic [4:0]         idx_reg, idx_next;
    logic               acc_reg, acc_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [23:0]        m_tdata_reg, m_tdata_next;

    // clamped register values
    logic [9:0]  bpm_c;
    logic [5:0]  bpb_c;
    logic [17:0] rate_c;
    logic        cfg_wr;

    assign bpm_c  = (bpm_reg < 10'(mcg_pkg::BPM_MIN)) ? 10'(mcg_pkg::BPM_MIN) :
                    (bpm_reg > 10'(mcg_pkg::BPM_MAX)) ? 10'(mcg_pkg::BPM_MAX) : bpm_reg;
    assign bpb_c  = (bpb_reg == 6'd0) ? 6'd1 :
                    (bpb_reg > 6'(mcg_pkg::MAX_BAR_BEATS)) ? 6'(mcg_pkg::MAX_BAR_BEATS)
                                                            : bpb_reg;
    assign rate_c = (rate_reg < 18'(mcg_pkg::RATE_MIN)) ? 18'(mcg_pkg::RATE_MIN) :
                    (rate_reg > 18'(mcg_pkg::RATE_MAX)) ? 18'(mcg_pkg::RATE_MAX) : rate_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[3:2])
            mcg_pkg::REG_BPM:  prdata = {22'd0, bpm_reg};
            mcg_pkg::REG_BPB:  prdata = {26'd0, bpb_reg};
            mcg_pkg::REG_RATE: prdata = {14'd0, rate_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpm_reg   <= 10'd120;
            bpb_reg   <= 6'd4;
            rate_reg  <= 18'd48000;
            stale_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    mcg_pkg::REG_BPM:  bpm_reg  <= pwdata[9:0];
                    mcg_pkg::REG_BPB:  bpb_reg  <= pwdata[5:0];
                    mcg_pkg::REG_RATE: rate_reg <= pwdata[17:0];
                    default: ;
                endcase
            end
            if (cfg_wr && (paddr[3:2] == mcg_pkg::REG_BPM || paddr[3:2] == mcg_pkg::REG_BPB
                           || paddr[3:2] == mcg_pkg::REG_RATE))
                stale_reg <= 1'b1;
            else if (state_reg == mcg_pkg::S_IDLE && s_tvalid && s_tdata[0])
                stale_reg <= 1'b1;
            else if (stale_clr)
                stale_reg <= 1'b0;
        end
    end

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            mcg_pkg::S_DIV_LD:
            begin
                mul_a = 33'(rate_c[17:3]);
                mul_b = 33'(mcg_pkg::CLICK_RECIP);
            end
            mcg_pkg::S_MUL_T:
            begin
                mul_a = 33'(cfl_reg);
                mul_b = 33'(escale_reg);
            end
            mcg_pkg::S_MUL_ENV:
            begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = {1'b0, prod_reg[31:0]};
            end
            mcg_pkg::S_MUL_SG:
            begin
                mul_a = 33'(mcg_pkg::SINE_TABLE[phase_reg[PB-1 -: mcg_pkg::SINE_IDX_BITS]]);
                mul_b = 33'(gain_reg);
            end
            mcg_pkg::S_MUL_P:
            begin
                mul_a = 33'(signed'(prod_reg[31:0]));
                mul_b = 33'(env_reg);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // one restoring divider step
    assign rem_shift = {rem_reg[DW-1:0], quo_reg[NW-1]};

    // sequencer
    always_comb
    begin
        logic signed [63:0] q31;
        logic [NW-1:0]      dnum;
        logic [DW-1:0]      dden;

        state_next    = state_reg;
        ftb_next      = ftb_reg;
        bar_next      = bar_reg;
        cfl_next      = cfl_reg;
        phase_next    = phase_reg;
        step_next     = step_reg;
        gain_next     = gain_reg;
        period_next   = period_reg;
        clen_next     = clen_reg;
        escale_next   = escale_reg;
        nstep_next    = nstep_reg;
        astep_next    = astep_reg;
        stale_clr     = 1'b0;
        dsel_next     = dsel_reg;
        dcnt_next     = dcnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        mod_next      = mod_reg;
        prod_next     = prod_reg;
        env_next      = env_reg;
        smp_next      = smp_reg;
        beat_next     = beat_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        q31           = '0;
        dnum          = '0;
        dden          = '0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            mcg_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tdata[0])
                    begin
                        bar_next = '0;
                        cfl_next = '0;
                        ftb_next = '0;
                    end
                    dsel_next = mcg_pkg::DIV_BEAT_PERIOD;
                    if (stale_reg || s_tdata[0])
                        state_next = mcg_pkg::S_DIV_LD;
                    else
                        state_next = mcg_pkg::S_BEAT;
                end
            end

            // load divider operands for the current derivation step, or take the click length from the multiplier
            mcg_pkg::S_DIV_LD:
            begin
                if (dsel_reg == mcg_pkg::DIV_CLICK_LEN)
                begin
                    // click length by reciprocal multiply, no divider pass
                    clen_next = mul_p[29:20];
                    dsel_next = mcg_pkg::DIV_ENV_SCALE;
                end
                else
                begin
                    case (dsel_reg)
                        mcg_pkg::DIV_BEAT_PERIOD:
                        begin
                            dnum = NW'(rate_c) * NW'(mcg_pkg::SECONDS_PER_MIN);
                            dden = DW'(bpm_c);
                        end
                        mcg_pkg::DIV_ENV_SCALE:
                        begin
                            dnum = NW'(65536) + NW'(clen_reg[9:1]);
                            dden = DW'(clen_reg);
                        end
                        mcg_pkg::DIV_NORMAL_STEP:
                        begin
                            dnum = (NW'(mcg_pkg::NORMAL_FREQ_HZ) << PB) + NW'(rate_c[17:1]);
                            dden = DW'(rate_c);
                        end
                        default:
                        begin
                            dnum = (NW'(mcg_pkg::ACCENT_FREQ_HZ) << PB) + NW'(rate_c[17:1]);
                            dden = DW'(rate_c);
                        end
                    endcase
                    quo_next   = dnum;
                    den_next   = dden;
                    rem_next   = '0;
                    dcnt_next  = CW'(NW - 1);
                    state_next = mcg_pkg::S_DIV;
                end
            end

            mcg_pkg::S_DIV:
            begin
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_next = rem_shift - {1'b0, den_reg};
                    quo_next = {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[NW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == '0)
                begin
                    case (dsel_reg)
                        mcg_pkg::DIV_BEAT_PERIOD: period_next = quo_next[23:0];
                        mcg_pkg::DIV_ENV_SCALE:   escale_next = quo_next[16:0];
                        mcg_pkg::DIV_NORMAL_STEP: nstep_next  = quo_next[PB-1:0];
                        default:                  astep_next  = quo_next[PB-1:0];
                    endcase
                    if (dsel_reg == mcg_pkg::DIV_ACCENT_STEP)
                    begin
                        stale_clr  = 1'b1;
                        state_next = mcg_pkg::S_BEAT;
                    end
                    else
                    begin
                        dsel_next  = dsel_reg + 3'd1;
                        state_next = mcg_pkg::S_DIV_LD;
                    end
                end
            end

            mcg_pkg::S_BEAT:
            begin
                if (ftb_reg == '0)
                begin
                    beat_next  = 1'b1;
                    idx_next   = 5'(bar_reg);
                    acc_next   = (bar_reg == '0);
                    cfl_next   = clen_reg;
                    phase_next = '0;
                    step_next  = (bar_reg == '0) ? astep_reg : nstep_reg;
                    gain_next  = (bar_reg == '0) ? 15'(mcg_pkg::ACCENT_GAIN_Q15)
                                                 : 15'(mcg_pkg::NORMAL_GAIN_Q15);
                    mod_next   = {1'b0, bar_reg} + 1'b1;
                    ftb_next   = (period_reg != '0) ? period_reg - 1'b1 : '0;
                    state_next = mcg_pkg::S_MOD;
                end
                else
                begin
                    beat_next = 1'b0;
                    idx_next  = '0;
                    acc_next  = 1'b0;
                    ftb_next  = ftb_reg - 1'b1;
                    smp_next  = '0;
                    state_next = (cfl_reg != '0) ? mcg_pkg::S_MUL_T : mcg_pkg::S_OUT;
                end
            end

            // bar position wrap by repeated subtraction
            mcg_pkg::S_MOD:
            begin
                if (7'(mod_reg) >= 7'(bpb_c))
                    mod_next = 6'(7'(mod_reg) - 7'(bpb_c));
                else
                begin
                    bar_next   = mod_reg[BB-1:0];
                    smp_next   = '0;
                    state_next = (cfl_reg != '0) ? mcg_pkg::S_MUL_T : mcg_pkg::S_OUT;
                end
            end

            mcg_pkg::S_MUL_T:
            begin
                prod_next  = mul_p[63:0];
                state_next = mcg_pkg::S_MUL_ENV;
            end

            mcg_pkg::S_MUL_ENV:
            begin
                if (mul_p[63:16] > 48'd65536)
                    env_next = 17'd65536;
                else
                    env_next = mul_p[32:16];
                state_next = mcg_pkg::S_MUL_SG;
            end

            mcg_pkg::S_MUL_SG:
            begin
                prod_next  = mul_p[63:0];
                state_next = mcg_pkg::S_MUL_P;
            end

            mcg_pkg::S_MUL_P:
            begin
                prod_next  = mul_p[63:0];
                state_next = mcg_pkg::S_SAMPLE;
            end

            // divide by 2^31 toward zero, then clamp
            mcg_pkg::S_SAMPLE:
            begin
                q31 = prod_reg >>> 31;
                if (prod_reg[63] && prod_reg[30:0] != '0)
                    q31 = q31 + 64'sd1;
                if (q31 > 64'sd32767)
                    smp_next = 16'sd32767;
                else if (q31 < -64'sd32767)
                    smp_next = -16'sd32767;
                else
                    smp_next = q31[15:0];
                phase_next = phase_reg + step_reg;
                cfl_next   = cfl_reg - 1'b1;
                state_next = mcg_pkg::S_OUT;
            end

            mcg_pkg::S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, acc_reg, idx_reg, beat_reg, smp_reg};
                    state_next    = mcg_pkg::S_IDLE;
                end
            end

            default: state_next = mcg_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mcg_pkg::S_IDLE;
            ftb_reg      <= '0;
            bar_reg      <= '0;
            cfl_reg      <= '0;
            phase_reg    <= '0;
            step_reg     <= '0;
            gain_reg     <= '0;
            period_reg   <= '0;
            clen_reg     <= '0;
            escale_reg   <= '0;
            nstep_reg    <= '0;
            astep_reg    <= '0;
            dsel_reg     <= '0;
            dcnt_reg     <= '0;
            mod_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ftb_reg      <= ftb_next;
            bar_reg      <= bar_next;
            cfl_reg      <= cfl_next;
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            gain_reg     <= gain_next;
            period_reg   <= period_next;
            clen_reg     <= clen_next;
            escale_reg   <= escale_next;
            nstep_reg    <= nstep_next;
            astep_reg    <= astep_next;
            dsel_reg     <= dsel_next;
            dcnt_reg     <= dcnt_next;
            mod_reg      <= mod_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        prod_reg    <= prod_next;
        env_reg     <= env_next;
        smp_reg     <= smp_next;
        beat_reg    <= beat_next;
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == mcg_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
